@@ hw/rtl/lpcsf_pkg.sv @@
// shared types and constants for the lpc synthesis filter
package lpcsf_pkg;

  localparam int DEF_MAX_ORDER = 32;
  localparam int DEF_MAX_UNITS = 4;

  localparam int DW         = 32;
  localparam int TAPS_W     = 6;
  localparam int SHIFT_W    = 5;
  localparam int UNIT_W     = 2;
  localparam int TAP_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // input item kinds
  localparam logic KIND_COEF   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_RESULT,
    ST_EMIT
  } seq_state_t;

  // sequencer to multiply-accumulate unit
  typedef struct packed {
    logic init;
    logic step;
  } mac_ctl_t;

endpackage

@@ hw/rtl/lpcsf_if.sv @@
// valid/ready channels for input items and synthesized samples
interface lpcsf_in_if import lpcsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [UNIT_W-1:0]    unit;
  logic [TAP_W-1:0]     tap;
  logic signed [DW-1:0] value;
  logic                 unit_start;

  modport source (output valid, kind, unit, tap, value, unit_start, input ready);
  modport sink   (input valid, kind, unit, tap, value, unit_start, output ready);
endinterface

interface lpcsf_out_if import lpcsf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

@@ hw/rtl/lpc_synthesis_filter.sv @@
// top level of the recursive lpc synthesis filter
//
//  channel  dir  payload                              handshake
//  din      in   kind, unit, tap, value, unit_start   valid/ready
//  dout     out  sample_out                           valid/ready
//  cfg      in   cfg_index, cfg_data                  cfg_we, no back-pressure
//
// a coefficient load leaves din ready; a pass-through sample goes straight to the emit state;
// a predicted sample passes the mac, result and emit states, at order zero only the last two,
// with one multiply-accumulate per tap through the shared multiplier and one read port per ram
// din is not ready while a sample is worked on; a result waiting in the
// output register only holds the block once the next result is finished
// reset clears config, history fill and handshakes; ram contents are not cleared
module lpc_synthesis_filter import lpcsf_pkg::*; #(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int MAX_UNITS = DEF_MAX_UNITS
) (
  input  logic                  clk,
  input  logic                  rst,
  lpcsf_in_if.sink              din,
  lpcsf_out_if.source           dout,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int OW  = $clog2(MAX_ORDER + 1);
  localparam int AW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CD  = MAX_UNITS * MAX_ORDER;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;

  logic [TAPS_W-1:0]    taps_per_unit;
  logic [SHIFT_W-1:0]   shift;
  logic [OW-1:0]        order;
  logic                 out_valid;
  logic signed [DW-1:0] out_data;
  logic                 out_free;
  logic                 emit;
  logic signed [DW-1:0] res;
  logic signed [DW-1:0] value_q;
  logic signed [DW-1:0] mac_result;
  mac_ctl_t             mac_ctl;
  logic                 hist_we;
  logic [AW-1:0]        hist_waddr;
  logic [DW-1:0]        hist_wdata;
  logic [AW-1:0]        hist_raddr;
  logic [DW-1:0]        hist_rd;
  logic                 coef_we;
  logic [CAW-1:0]       coef_waddr;
  logic [CAW-1:0]       coef_raddr;
  logic [DW-1:0]        coef_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_per_unit <= '0;
      shift         <= SHIFT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAPS:  taps_per_unit <= cfg_data;
        CFG_SHIFT: shift         <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // order saturates at the history depth
  assign order = ({1'b0, taps_per_unit} > 7'(MAX_ORDER)) ? OW'(MAX_ORDER)
                                                         : OW'(taps_per_unit);

  lpcsf_seq #(
    .MAX_ORDER (MAX_ORDER),
    .MAX_UNITS (MAX_UNITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .din        (din),
    .order      (order),
    .out_free   (out_free),
    .hist_rd    (hist_rd),
    .mac_result (mac_result),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .hist_raddr (hist_raddr),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_raddr (coef_raddr),
    .mac_ctl    (mac_ctl),
    .value_q    (value_q),
    .emit       (emit),
    .res        (res)
  );

  lpcsf_ram #(
    .DEPTH (CD),
    .WIDTH (DW)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (din.value),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  lpcsf_ram #(
    .DEPTH (MAX_ORDER),
    .WIDTH (DW)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rd)
  );

  lpcsf_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mac_ctl),
    .coef_rd (coef_rd),
    .hist_rd (hist_rd),
    .shift   (shift),
    .value   (value_q),
    .result  (mac_result)
  );

  // output register, refilled once the waiting beat is taken
  assign out_free = !out_valid || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.sample_out = out_data;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!dout.valid || dout.ready))
    else $error("result beat overwritten before it was taken");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> dout.valid)
    else $error("finished result not presented");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.kind == KIND_COEF) |=> din.ready)
    else $error("coefficient load did not complete in one cycle");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.kind == KIND_SAMPLE) |=> !din.ready)
    else $error("input taken while a sample is in progress");

endmodule

@@ hw/rtl/lpcsf_ram.sv @@
// simple dual-port ram, one write and one registered read per cycle
module lpcsf_ram #(
  parameter  int DEPTH = 32,
  parameter  int WIDTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/lpcsf_mac.sv @@
// shared multiply-accumulate unit with rounding shift and final subtract
module lpcsf_mac import lpcsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  mac_ctl_t             ctl,
  input  logic [DW-1:0]        coef_rd,
  input  logic [DW-1:0]        hist_rd,
  input  logic [SHIFT_W-1:0]   shift,
  input  logic signed [DW-1:0] value,
  output logic signed [DW-1:0] result
);

  logic [DW-1:0]        prod;
  logic                 prod_vld;
  logic [DW-1:0]        acc;
  logic [DW-1:0]        half;
  logic signed [DW-1:0] pred;

  assign half = (shift == '0) ? '0 : (DW'(1) << (shift - SHIFT_W'(1)));

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.step;
    end
  end

  // low 32 bits of the product, registered before the add
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod <= DW'(coef_rd * hist_rd);
    end
    if (ctl.init) begin
      acc <= half;
    end else if (prod_vld) begin
      acc <= acc + prod;
    end
  end

  assign pred   = signed'(acc) >>> shift;
  assign result = value - pred;

endmodule

@@ hw/rtl/lpcsf_seq.sv @@
// sequencer: item decode, history fill, tap counter and write-back control
module lpcsf_seq import lpcsf_pkg::*; #(
  parameter  int MAX_ORDER = DEF_MAX_ORDER,
  parameter  int MAX_UNITS = DEF_MAX_UNITS,
  localparam int OW  = $clog2(MAX_ORDER + 1),
  localparam int AW  = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1,
  localparam int CD  = MAX_UNITS * MAX_ORDER,
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  lpcsf_in_if.sink             din,
  input  logic [OW-1:0]        order,
  input  logic                 out_free,
  input  logic [DW-1:0]        hist_rd,
  input  logic signed [DW-1:0] mac_result,
  output logic                 hist_we,
  output logic [AW-1:0]        hist_waddr,
  output logic [DW-1:0]        hist_wdata,
  output logic [AW-1:0]        hist_raddr,
  output logic                 coef_we,
  output logic [CAW-1:0]       coef_waddr,
  output logic [CAW-1:0]       coef_raddr,
  output mac_ctl_t             mac_ctl,
  output logic signed [DW-1:0] value_q,
  output logic                 emit,
  output logic signed [DW-1:0] res
);

  localparam int UW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

  seq_state_t           state, state_next;
  logic [OW-1:0]        fill;
  logic [OW-1:0]        fill_eff;
  logic [OW-1:0]        iss;
  logic                 v1, v2;
  logic [AW-1:0]        v1_idx;
  logic [UW-1:0]        unit_q;
  logic [UW-1:0]        unit_m;
  logic [UNIT_W-1:0]    unit_w;
  logic                 accept;
  logic                 is_sample;
  logic                 not_full;
  logic                 issue;

  // unit index wraps at the unit count
  always_comb begin
    unit_w = din.unit;
    for (int i = 0; i < 3; i++) begin
      if ({2'b00, unit_w} >= 4'(MAX_UNITS)) begin
        unit_w = unit_w - UNIT_W'(MAX_UNITS);
      end
    end
    unit_m = UW'(unit_w);
  end

  assign din.ready = (state == ST_IDLE);
  assign accept    = din.valid && din.ready;
  assign is_sample = (din.kind == KIND_SAMPLE);
  assign fill_eff  = din.unit_start ? '0 : ((fill > order) ? order : fill);
  assign not_full  = (fill_eff < order);
  assign issue     = (state == ST_MAC) && (iss < order);

  assign coef_we    = accept && !is_sample && (int'(din.tap) < MAX_ORDER);
  assign coef_waddr = CAW'(int'(unit_m) * MAX_ORDER + int'(din.tap));
  assign coef_raddr = CAW'(int'(unit_q) * MAX_ORDER + int'(iss));
  assign hist_raddr = AW'(iss);

  assign mac_ctl.init = accept && is_sample && !not_full;
  assign mac_ctl.step = v1;

  // one write port shared by fill, shift-down and write-back
  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = AW'(fill_eff);
    hist_wdata = din.value;
    if (state == ST_IDLE) begin
      hist_we = accept && is_sample && not_full;
    end else if (state == ST_MAC) begin
      hist_we    = v1 && (v1_idx != '0);
      hist_waddr = v1_idx - AW'(1);
      hist_wdata = hist_rd;
    end else if (state == ST_RESULT) begin
      hist_we    = (order != '0);
      hist_waddr = AW'(order - OW'(1));
      hist_wdata = mac_result;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_sample) begin
          if (not_full) begin
            state_next = ST_EMIT;
          end else if (order == '0) begin
            state_next = ST_RESULT;
          end else begin
            state_next = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (!issue && !v1 && !v2) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      if (accept && is_sample) begin
        fill <= not_full ? fill_eff + OW'(1) : fill_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    v1_idx <= AW'(iss);
    if (accept) begin
      value_q <= din.value;
      unit_q  <= unit_m;
      iss     <= '0;
      res     <= din.value;
    end else if (issue) begin
      iss <= iss + OW'(1);
    end
    if (state == ST_RESULT) begin
      res <= mac_result;
    end
  end

endmodule

@@ tb/tb.sv @@
// testbench for the lpc synthesis filter: stimulus, prediction and result checks
module tb;
  import lpcsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ORDER = DEF_MAX_ORDER;
  localparam int MAX_UNITS = DEF_MAX_UNITS;

  typedef struct {
    logic                 kind;
    logic [UNIT_W-1:0]    unit;
    logic [TAP_W-1:0]     tap;
    logic signed [DW-1:0] value;
    logic                 unit_start;
  } filter_beat_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lpcsf_in_if  din_ch ();
  lpcsf_out_if dout_ch ();

  lpc_synthesis_filter dut (
    .clk       (clk),
    .rst       (rst),
    .din       (din_ch),
    .dout      (dout_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  logic [DW-1:0]        coef_bank [MAX_UNITS][MAX_ORDER];
  logic [DW-1:0]        history [MAX_ORDER];
  int unsigned          hist_fill;
  int unsigned          model_taps;
  int unsigned          model_shift;

  filter_beat_t         pending_beats [$];
  logic signed [DW-1:0] expected_samples [$];

  filter_beat_t cur_beat;
  int  tx_gap;
  int  rx_stall;
  int  hold_cnt;
  bit  hold_done;
  bit  calm;
  int  fail_cnt;
  int  beats_in;
  int  coef_loads;
  int  predicted_cnt;
  int  samples_seen;
  int  settings_cnt;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DW-1:0] pick_value();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -32'sd1;
      4, 5, 6: return {{16{h[15]}}, h};
      default: return $urandom;
    endcase
  endfunction

  // recursive synthesis of one accepted beat
  task automatic synth_predict(input filter_beat_t b);
    int unsigned   order;
    logic [DW-1:0] acc;
    logic [DW-1:0] prod;
    logic [DW-1:0] res;
    if (b.kind == KIND_COEF) begin
      coef_bank[b.unit][b.tap] = b.value;
      coef_loads++;
      return;
    end
    order = (model_taps > MAX_ORDER) ? MAX_ORDER : model_taps;
    if (b.unit_start) hist_fill = 0;
    if (hist_fill > order) hist_fill = order;
    if (hist_fill < order) begin
      res = b.value;
      history[hist_fill] = b.value;
      hist_fill++;
    end else begin
      acc = (model_shift == 0) ? '0 : (32'd1 << (model_shift - 1));
      for (int k = 0; k < order; k++) begin
        prod = coef_bank[b.unit][k] * history[k];
        acc  = acc + prod;
      end
      res = b.value - ($signed(acc) >>> model_shift);
      if (order > 0) begin
        for (int k = 0; k + 1 < order; k++) history[k] = history[k + 1];
        history[order - 1] = res;
      end
      predicted_cnt++;
    end
    expected_samples.push_back(res);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      din_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else if (!(din_ch.valid && !din_ch.ready)) begin
      if (din_ch.valid && din_ch.ready) begin
        synth_predict(cur_beat);
        beats_in++;
      end
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        din_ch.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        din_ch.kind       <= cur_beat.kind;
        din_ch.unit       <= cur_beat.unit;
        din_ch.tap        <= cur_beat.tap;
        din_ch.value      <= cur_beat.value;
        din_ch.unit_start <= cur_beat.unit_start;
        din_ch.valid      <= 1'b1;
        tx_gap <= pick_gap();
      end else begin
        din_ch.valid <= 1'b0;
      end
    end
  end

  // output monitor and ready generation
  always @(posedge clk) begin
    logic signed [DW-1:0] want;
    if (rst) begin
      dout_ch.ready <= 1'b0;
      rx_stall <= 0;
      hold_cnt <= 0;
    end else begin
      if (dout_ch.valid && dout_ch.ready) begin
        samples_seen++;
        if (expected_samples.size() == 0) begin
          $error("sample_out with nothing expected: expected none, got %0d",
                 dout_ch.sample_out);
          fail_cnt++;
        end else begin
          want = expected_samples.pop_front();
          if (dout_ch.sample_out !== want) begin
            $error("sample_out mismatch: expected %0d, got %0d", want, dout_ch.sample_out);
            fail_cnt++;
          end
        end
      end
      // one long hold so the block backs up into its input
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        dout_ch.ready <= 1'b0;
      end else if (!hold_done && samples_seen >= 150) begin
        hold_done <= 1'b1;
        hold_cnt <= 300;
        dout_ch.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall <= rx_stall - 1;
        dout_ch.ready <= 1'b0;
      end else begin
        dout_ch.ready <= 1'b1;
        rx_stall <= pick_gap();
      end
    end
  end

  task automatic push_load(input logic [UNIT_W-1:0] unit, input logic [TAP_W-1:0] tap,
                           input logic signed [DW-1:0] value);
    filter_beat_t b;
    b.kind = KIND_COEF;
    b.unit = unit;
    b.tap = tap;
    b.value = value;
    b.unit_start = 1'($urandom_range(1));
    pending_beats.push_back(b);
  endtask

  task automatic push_sample(input logic [UNIT_W-1:0] unit, input logic signed [DW-1:0] value,
                             input logic start);
    filter_beat_t b;
    b.kind = KIND_SAMPLE;
    b.unit = unit;
    b.tap = TAP_W'($urandom_range(31));
    b.value = value;
    b.unit_start = start;
    pending_beats.push_back(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_TAPS) model_taps = data & 6'h3f;
    else model_shift = data & 5'h1f;
  endtask

  task automatic set_filter(input int taps, input int shft);
    write_reg(CFG_TAPS, taps);
    write_reg(CFG_SHIFT, shft);
    settings_cnt++;
  endtask

  // all beats accepted and all samples back, then room for a trailing load
  task automatic settle();
    while (pending_beats.size() > 0 || din_ch.valid || expected_samples.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(input int n_beats, input int taps, input int shft);
    int run_left;
    int ord;
    int r;
    logic [UNIT_W-1:0] run_unit;
    bit first;
    run_left = 0;
    run_unit = '0;
    first = 1'b0;
    set_filter(taps, shft);
    ord = (taps > MAX_ORDER) ? MAX_ORDER : taps;
    calm = ($urandom_range(3) == 0);
    for (int i = 0; i < n_beats; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_load(UNIT_W'($urandom_range(3)), TAP_W'($urandom_range(31)), pick_value());
      end else if (r < 12) begin
        // stray sample on a random bank, continuing the history
        push_sample(UNIT_W'($urandom_range(3)), pick_value(), 1'b0);
      end else begin
        if (run_left == 0) begin
          run_unit = UNIT_W'($urandom_range(3));
          run_left = $urandom_range(1, ord + 12);
          first = 1'b1;
        end
        push_sample(run_unit, pick_value(), first && ($urandom_range(4) != 0));
        first = 1'b0;
        run_left--;
      end
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    din_ch.valid = 1'b0;
    din_ch.kind = KIND_COEF;
    din_ch.unit = '0;
    din_ch.tap = '0;
    din_ch.value = '0;
    din_ch.unit_start = 1'b0;
    dout_ch.ready = 1'b0;
    hist_fill = 0;
    model_taps = 0;
    model_shift = 1;
    hold_done = 1'b0;
    calm = 1'b0;
    fail_cnt = 0;
    beats_in = 0;
    coef_loads = 0;
    predicted_cnt = 0;
    samples_seen = 0;
    settings_cnt = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // zero order at reset: samples pass, the first one without a start
    push_sample(2'd3, 32'sh7fff_ffff, 1'b0);
    push_sample(2'd0, 32'sh8000_0000, 1'b1);
    push_sample(2'd1, -32'sd1, 1'b0);

    // fill every bank so no unwritten coefficient is ever used
    for (int u = 0; u < MAX_UNITS; u++)
      for (int t = 0; t < MAX_ORDER; t++)
        push_load(UNIT_W'(u), TAP_W'(t), pick_value());
    push_load(2'd0, 5'd0, 32'sh8000_0000);
    push_load(2'd0, 5'd1, 32'sh7fff_ffff);
    push_load(2'd0, 5'd2, -32'sd1);
    push_load(2'd0, 5'd3, 32'sd1);
    settle();

    // extreme coefficients and samples, widest shift
    set_filter(4, 31);
    push_sample(2'd0, 32'sh7fff_ffff, 1'b1);
    push_sample(2'd0, 32'sh8000_0000, 1'b0);
    push_sample(2'd0, -32'sd1, 1'b0);
    push_sample(2'd0, 32'sh7fff_ffff, 1'b0);
    push_sample(2'd0, 32'sh8000_0000, 1'b0);
    push_sample(2'd0, '0, 1'b0);
    push_sample(2'd0, 32'sh7fff_ffff, 1'b0);
    push_sample(2'd0, -32'sd1, 1'b0);
    settle();

    // order shrinks mid-unit with no shift at all
    set_filter(2, 0);
    push_sample(2'd0, 32'sh0000_1234, 1'b0);
    push_sample(2'd0, -32'sd7, 1'b0);
    push_sample(2'd0, 32'sh8000_0000, 1'b0);
    settle();

    // order above the maximum saturates and grows past the fill
    set_filter(63, 16);
    push_sample(2'd0, 32'sd5, 1'b0);
    push_sample(2'd1, 32'sh7fff_ffff, 1'b0);
    push_sample(2'd3, 32'sh8000_0000, 1'b0);
    settle();

    run_phase(55, 1, 1);
    run_phase(55, 2, 31);
    run_phase(55, 8, 12);
    run_phase(55, 0, 5);
    run_phase(25, 32, 15);
    run_phase(55, 3, 0);
    run_phase(25, 16, 20);
    run_phase(25, 63, 8);
    run_phase(55, 5, 1);
    run_phase(55, 12, 31);

    repeat (50) @(posedge clk);
    $display("covered %0d input beats (%0d coefficient loads) over %0d filter settings",
             beats_in, coef_loads, settings_cnt);
    $display("checked %0d samples, %0d of them through the predictor",
             samples_seen, predicted_cnt);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout waiting for the filter");
    $display("tb NOT OK");
    $finish;
  end

endmodule
